FILE: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TFCE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is high.
`define TFCE_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define TFCE_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/tfce_pkg.sv
package tfce_pkg;

  // Default depth of the character buffer.
  localparam int BufferLengthDef = 2048;

  // Request kinds.
  typedef enum logic [2:0] {
    KIND_KEY   = 3'd0,
    KIND_CLEAR = 3'd1,
    KIND_ARM   = 3'd2,
    KIND_PEEK  = 3'd3,
    KIND_FLUSH = 3'd4
  } kind_t;

  // Key codes and characters.
  localparam logic [7:0] KeyBackspace = 8'h08;
  localparam logic [7:0] KeyTab       = 8'h09;
  localparam logic [7:0] KeyReturn    = 8'h0A;
  localparam logic [7:0] ChMask       = 8'h2A;
  localparam logic [7:0] ChNewline    = 8'h0A;
  localparam logic [7:0] ChNul        = 8'h00;

  // Configuration register indexes.
  localparam logic [2:0] CfgLeft   = 3'd0;
  localparam logic [2:0] CfgTop    = 3'd1;
  localparam logic [2:0] CfgWidth  = 3'd2;
  localparam logic [2:0] CfgHeight = 3'd3;
  localparam logic [2:0] CfgMask   = 3'd4;

  // Frame reset values.
  localparam logic [6:0] FrameWidthRst  = 7'd80;
  localparam logic [4:0] FrameHeightRst = 5'd25;

  typedef struct packed {
    logic [6:0] left;
    logic [4:0] top;
    logic [6:0] width;
    logic [4:0] height;
    logic       mask;
  } frame_t;

  // What one request does, decided from the cursor at acceptance.
  typedef struct packed {
    logic [6:0] next_col;
    logic [4:0] next_row;
    logic       next_reading;
    logic       load_wanted;
    logic       scr_wr;
    logic       store_wr;
    logic [6:0] pos_col;
    logic [4:0] pos_row;
    logic [7:0] store_ch;
    logic [7:0] scr_ch;
    logic       clr;
    logic       done;
    logic       peek;
    logic       flush;
  } action_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_MUL   = 5'b00100,
    S_IDX   = 5'b01000,
    S_RES   = 5'b10000
  } state_t;

endpackage

FILE: sv/tfce_ram.sv
module tfce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/tfce_cursor.sv
module tfce_cursor import tfce_pkg::*; (
  input  logic [6:0] cur_col,
  input  logic [4:0] cur_row,
  input  logic       reading,
  input  frame_t     frame,
  input  logic [2:0] kind,
  input  logic [7:0] key,
  output action_t    act
);

  logic signed [9:0] x, y, l, t, endc, endr, lastc, lastr;

  // Cursor and frame edges as small signed numbers, so that an empty frame compares right.
  always_comb begin
    x     = signed'({3'b000, cur_col});
    y     = signed'({5'b00000, cur_row});
    l     = signed'({3'b000, frame.left});
    t     = signed'({5'b00000, frame.top});
    endc  = l + signed'({3'b000, frame.width});
    endr  = t + signed'({5'b00000, frame.height});
    lastc = endc - 10'sd1;
    lastr = endr - 10'sd1;
  end

  // Decide the cursor move and the store and screen writes.
  always_comb begin
    act              = '0;
    act.next_col     = cur_col;
    act.next_row     = cur_row;
    act.next_reading = reading;
    act.pos_col      = cur_col;
    act.pos_row      = cur_row;
    case (kind_t'(kind))
      KIND_KEY: begin
        if (key == KeyBackspace) begin
          if (!(x == l && y == t)) begin
            if (x > l) begin
              act.next_col = cur_col - 7'd1;
            end else if (x == l && y > t) begin
              act.next_col = lastc[6:0];
              act.next_row = cur_row - 5'd1;
            end
            // The erase lands on the new position.
            act.pos_col  = act.next_col;
            act.pos_row  = act.next_row;
            act.scr_wr   = 1'b1;
            act.store_wr = 1'b1;
            act.store_ch = ChNul;
            act.scr_ch   = ChNul;
          end
        end else if (key == KeyTab) begin
          act.next_col = cur_col;
        end else if (key == KeyReturn) begin
          if (reading) begin
            act.done         = 1'b1;
            act.next_reading = 1'b0;
          end else if (y < lastr) begin
            act.next_col = frame.left;
            act.next_row = cur_row + 5'd1;
            act.scr_wr   = 1'b1;
            act.store_wr = 1'b1;
            act.store_ch = ChNewline;
            act.scr_ch   = ChNul;
          end
        end else if (!(x >= endc || y >= endr)) begin
          if (x < lastc) begin
            act.next_col = cur_col + 7'd1;
            act.scr_wr   = 1'b1;
          end else if (x == lastc && y < lastr) begin
            act.next_col = frame.left;
            act.next_row = cur_row + 5'd1;
            act.scr_wr   = 1'b1;
          end
          act.store_wr = act.scr_wr;
          act.store_ch = key;
          act.scr_ch   = frame.mask ? ChMask : key;
        end
      end
      KIND_CLEAR: begin
        act.next_col = frame.left;
        act.next_row = frame.top;
        act.clr      = 1'b1;
      end
      KIND_ARM: begin
        act.next_reading = 1'b1;
        act.load_wanted  = 1'b1;
      end
      KIND_PEEK: begin
        act.peek = 1'b1;
      end
      KIND_FLUSH: begin
        act.flush = 1'b1;
      end
      default: begin
        act.next_col = cur_col;
      end
    endcase
  end

endmodule

FILE: sv/tfce_index.sv
module tfce_index import tfce_pkg::*; #(
  parameter int BUFFER_LENGTH = BufferLengthDef,
  parameter int ADDR_W = $clog2(BUFFER_LENGTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic [6:0]        pos_col,
  input  logic [4:0]        pos_row,
  input  frame_t            frame,
  input  logic [15:0]       wanted,
  output logic              in_range,
  output logic [ADDR_W-1:0] addr,
  output logic [11:0]       rlen
);

  localparam logic [31:0] BufLen32 = 32'(BUFFER_LENGTH);

  logic [31:0] dx, dy, dx_q, prod_q, idx, imax, lim_a, lim_b;

  // Offsets from the frame origin, modulo 2^32.
  always_comb begin
    dx = {25'b0, pos_col} - {25'b0, frame.left};
    dy = {27'b0, pos_row} - {27'b0, frame.top};
  end

  // Row offset times frame width, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      dx_q   <= dx;
      prod_q <= dy * {25'b0, frame.width};
    end
  end

  // Buffer index, range check and the length a finished read may copy.
  always_comb begin
    idx      = dx_q + prod_q;
    in_range = idx < BufLen32;
    addr     = idx[ADDR_W-1:0];
    imax     = idx + 32'd1;
    lim_a    = {16'b0, wanted};
    if (lim_a > BufLen32) begin
      lim_a = BufLen32;
    end
    lim_b = (lim_a > imax) ? imax : lim_a;
    rlen  = lim_b[11:0];
  end

endmodule

FILE: sv/text_field_cursor_editor_top.sv
// An accepted request passes through the multiply, index and result states before its result is
// registered; a new request is taken only in the idle state, once the last result is loaded.
// A flush holds off new requests while the whole buffer is zeroed.
// Reset (synchronous, active high) clears cursor and read state, restores the frame,
// and starts a clearing pass over the whole buffer; configuration writes are taken throughout.
module text_field_cursor_editor_top import tfce_pkg::*; #(
  parameter int BUFFER_LENGTH = BufferLengthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  key_char,
  input  logic [15:0] requested_length,
  input  logic [10:0] peek_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        screen_write,
  output logic [6:0]  screen_col,
  output logic [4:0]  screen_row,
  output logic [7:0]  screen_char,
  output logic [6:0]  cursor_col,
  output logic [4:0]  cursor_row,
  output logic        clear_box,
  output logic        read_done,
  output logic [11:0] read_length,
  output logic [7:0]  buffer_char,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int ADDR_W = $clog2(BUFFER_LENGTH);
  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(BUFFER_LENGTH - 1);
  localparam logic [31:0] BufLen32 = 32'(BUFFER_LENGTH);

  state_t            state;
  frame_t            frame;
  logic [6:0]        cur_col;
  logic [4:0]        cur_row;
  logic              reading;
  logic [15:0]       wanted;
  logic [ADDR_W-1:0] sweep_cnt;
  action_t           act, act_q;
  logic [10:0]       pidx_q;
  logic              peek_ok;
  logic [31:0]       pidx32;
  logic              in_range;
  logic [ADDR_W-1:0] idx_addr;
  logic [11:0]       rlen;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              load_out;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_RES) && (!out_valid || out_ready);
  assign pidx32   = {21'b0, pidx_q};

  tfce_cursor u_cursor (
    .cur_col (cur_col),
    .cur_row (cur_row),
    .reading (reading),
    .frame   (frame),
    .kind    (kind),
    .key     (key_char),
    .act     (act)
  );

  tfce_index #(
    .BUFFER_LENGTH (BUFFER_LENGTH),
    .ADDR_W        (ADDR_W)
  ) u_index (
    .clk      (clk),
    .en       (state == S_MUL),
    .pos_col  (act_q.pos_col),
    .pos_row  (act_q.pos_row),
    .frame    (frame),
    .wanted   (wanted),
    .in_range (in_range),
    .addr     (idx_addr),
    .rlen     (rlen)
  );

  tfce_ram #(
    .WIDTH  (8),
    .DEPTH  (BUFFER_LENGTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Buffer port: the clearing pass, the write of a request, otherwise the peek address.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pidx32[ADDR_W-1:0];
    ram_wdata = ChNul;
    case (state)
      S_SWEEP: begin
        ram_we   = 1'b1;
        ram_addr = sweep_cnt;
      end
      S_IDX: begin
        if (act_q.clr) begin
          ram_we   = 1'b1;
          ram_addr = '0;
        end else if (act_q.store_wr && in_range) begin
          ram_we    = 1'b1;
          ram_addr  = idx_addr;
          ram_wdata = act_q.store_ch;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control state, cursor and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
      reading   <= 1'b0;
      wanted    <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      frame     <= '{left: 7'd0, top: 5'd0, width: FrameWidthRst,
                     height: FrameHeightRst, mask: 1'b0};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgLeft:   frame.left   <= cfg_data;
          CfgTop:    frame.top    <= cfg_data[4:0];
          CfgWidth:  frame.width  <= cfg_data;
          CfgHeight: frame.height <= cfg_data[4:0];
          CfgMask:   frame.mask   <= cfg_data[0];
          default:   frame        <= frame;
        endcase
      end
      // A taken result empties the output unless a new one is loaded in the same cycle.
      if (out_valid && out_ready && !load_out) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == LastAddr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur_col <= act.next_col;
            cur_row <= act.next_row;
            reading <= act.next_reading;
            if (act.load_wanted) begin
              wanted <= requested_length;
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_IDX;
        end
        S_IDX: begin
          state <= S_RES;
        end
        S_RES: begin
          if (load_out) begin
            out_valid <= 1'b1;
            sweep_cnt <= '0;
            state     <= act_q.flush ? S_SWEEP : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request payload held for the later steps.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      act_q   <= act;
      pidx_q  <= peek_index;
      peek_ok <= {21'b0, peek_index} < BufLen32;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      screen_write <= act_q.scr_wr;
      screen_col   <= act_q.scr_wr ? act_q.pos_col : 7'd0;
      screen_row   <= act_q.scr_wr ? act_q.pos_row : 5'd0;
      screen_char  <= act_q.scr_wr ? act_q.scr_ch : ChNul;
      cursor_col   <= cur_col;
      cursor_row   <= cur_row;
      clear_box    <= act_q.clr;
      read_done    <= act_q.done;
      read_length  <= act_q.done ? rlen : 12'd0;
      buffer_char  <= (act_q.peek && peek_ok) ? ram_rdata : ChNul;
    end
  end

endmodule

FILE: sv/tfce_checker.sv
`include "assert_macros.svh"

module tfce_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        screen_write,
  input logic [6:0]  screen_col,
  input logic [4:0]  screen_row,
  input logic [7:0]  screen_char,
  input logic [6:0]  cursor_col,
  input logic [4:0]  cursor_row,
  input logic        clear_box,
  input logic        read_done,
  input logic [11:0] read_length,
  input logic [7:0]  buffer_char
);

  // A stalled result keeps its values.
  `TFCE_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(screen_char) && $stable(cursor_col) && $stable(cursor_row) && $stable(read_length))

  // Without a screen write the position and character read as zero.
  `TFCE_ASSERT_IMP(a_no_write_zero, clk, rst, out_valid && !screen_write, screen_col == 7'd0 && screen_row == 5'd0 && screen_char == 8'd0)

  // A length is only reported when a read ends.
  `TFCE_ASSERT_IMP(a_len_with_done, clk, rst, out_valid && !read_done, read_length == 12'd0)

  // A clear result carries nothing else.
  `TFCE_ASSERT_IMP(a_clear_alone, clk, rst, out_valid && clear_box, !screen_write && !read_done && buffer_char == 8'd0)

  // The clearing pass after reset holds off requests.
  `TFCE_ASSERT_NXT_ALWAYS(a_reset_busy, clk, rst, !in_ready && !out_valid)

endmodule

bind text_field_cursor_editor_top tfce_checker u_tfce_checker (.*);

FILE: tb/sv/text_field_cursor_editor_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port of the text field editor, works out
// the screen update that each accepted request should give and compares the results.
module text_field_cursor_editor_checker import tfce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [7:0]  key_char,
  input  logic [15:0] requested_length,
  input  logic [10:0] peek_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        screen_write,
  input  logic [6:0]  screen_col,
  input  logic [4:0]  screen_row,
  input  logic [7:0]  screen_char,
  input  logic [6:0]  cursor_col,
  input  logic [4:0]  cursor_row,
  input  logic        clear_box,
  input  logic        read_done,
  input  logic [11:0] read_length,
  input  logic [7:0]  buffer_char,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          reads_finished
);

  localparam int BufLen = BufferLengthDef;
  localparam int SlotW  = $clog2(BufLen);

  typedef struct packed {
    logic        scr_wr;
    logic [6:0]  scr_col;
    logic [4:0]  scr_row;
    logic [7:0]  scr_ch;
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    logic        clr;
    logic        done;
    logic [11:0] rlen;
    logic [7:0]  bch;
  } screen_update_t;

  // Frame registers as the block should hold them.
  logic [6:0] frm_left;
  logic [4:0] frm_top;
  logic [6:0] frm_width;
  logic [4:0] frm_height;
  logic       frm_mask;

  // Editor state as the block should hold it.
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic        reading;
  logic [15:0] wanted;
  logic [7:0]  text_mem [BufLen];

  screen_update_t awaited_updates [$];

  int mismatch_total = 0;
  int checked_total = 0;
  int reads_total = 0;
  int awaited_total = 0;

  assign mismatches      = mismatch_total;
  assign outstanding     = awaited_total;
  assign results_checked = checked_total;
  assign reads_finished  = reads_total;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on result %0d: %s", $time, checked_total, what);
    mismatch_total++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic clear_text();
    text_mem = '{default: 8'h00};
  endtask

  // Buffer slot under the cursor, with the same 32-bit wrap as the hardware index.
  function automatic logic [31:0] text_slot();
    return (32'(cur_col) - 32'(frm_left)) + (32'(cur_row) - 32'(frm_top)) * 32'(frm_width);
  endfunction

  // Shows a character at the cursor and stores one there when the slot exists.
  task automatic show_and_store(input logic [7:0] store_ch, input logic [7:0] scr_ch,
                                inout screen_update_t upd);
    logic [31:0] slot;
    slot = text_slot();
    upd.scr_wr  = 1'b1;
    upd.scr_col = cur_col;
    upd.scr_row = cur_row;
    upd.scr_ch  = scr_ch;
    if (slot < 32'(BufLen)) text_mem[slot[SlotW-1:0]] = store_ch;
  endtask

  // Applies one request to the editor state and returns the update it causes.
  task automatic edit_text_field(input logic [2:0] k, input logic [7:0] ch,
                                 input logic [15:0] len, input logic [10:0] idx,
                                 output screen_update_t upd);
    int x, y, lft, tp, wid, hgt, lastc, lastr, nx, ny;
    logic [31:0] limit, reach;
    upd   = '0;
    x     = cur_col;
    y     = cur_row;
    lft   = frm_left;
    tp    = frm_top;
    wid   = frm_width;
    hgt   = frm_height;
    lastc = lft + wid - 1;
    lastr = tp + hgt - 1;
    case (k)
      KIND_KEY: begin
        if (ch == KeyBackspace) begin
          // Nothing happens at the frame origin; elsewhere step back, across row ends too.
          if (!(x == lft && y == tp)) begin
            if (x > lft) begin
              x--;
            end else if (x == lft && y > tp) begin
              x = lastc;
              y--;
            end
            cur_col = 7'(x);
            cur_row = 5'(y);
            show_and_store(ChNul, ChNul, upd);
          end
        end else if (ch == KeyTab) begin
          // Tab has no effect.
        end else if (ch == KeyReturn) begin
          if (reading) begin
            // An armed read ends and reports the shortest of three lengths.
            limit   = 32'(wanted);
            reach   = text_slot() + 32'd1;
            reading = 1'b0;
            if (limit > 32'(BufLen)) limit = 32'(BufLen);
            if (limit > reach) limit = reach;
            upd.done = 1'b1;
            upd.rlen = 12'(limit);
          end else if (y < lastr) begin
            show_and_store(ChNewline, ChNul, upd);
            cur_col = 7'(lft);
            cur_row = 5'(y + 1);
          end
        end else if (!(x >= lft + wid || y >= tp + hgt)) begin
          // Ordinary key: advance and wrap; the last cell neither moves nor writes.
          nx = x;
          ny = y;
          if (x < lastc) begin
            nx = x + 1;
          end else if (x == lastc && y < lastr) begin
            nx = lft;
            ny = y + 1;
          end
          if (nx != x || ny != y) show_and_store(ch, frm_mask ? ChMask : ch, upd);
          cur_col = 7'(nx);
          cur_row = 5'(ny);
        end
      end
      KIND_CLEAR: begin
        cur_col     = frm_left;
        cur_row     = frm_top;
        text_mem[0] = 8'h00;
        upd.clr     = 1'b1;
      end
      KIND_ARM: begin
        reading = 1'b1;
        wanted  = len;
      end
      KIND_PEEK: begin
        if (int'(idx) < BufLen) upd.bch = text_mem[idx];
      end
      KIND_FLUSH: begin
        clear_text();
      end
      default: begin
      end
    endcase
    upd.cur_col = cur_col;
    upd.cur_row = cur_row;
  endtask

  // Reset, register writes, result comparison and prediction, all on the rising edge.
  always @(posedge clk) begin
    screen_update_t fresh, want;
    if (rst) begin
      frm_left   = 7'd0;
      frm_top    = 5'd0;
      frm_width  = FrameWidthRst;
      frm_height = FrameHeightRst;
      frm_mask   = 1'b0;
      cur_col    = 7'd0;
      cur_row    = 5'd0;
      reading    = 1'b0;
      wanted     = 16'd0;
      clear_text();
      awaited_updates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgLeft:   frm_left = cfg_data;
          CfgTop:    frm_top = cfg_data[4:0];
          CfgWidth:  frm_width = cfg_data;
          CfgHeight: frm_height = cfg_data[4:0];
          CfgMask:   frm_mask = cfg_data[0];
          default: begin
          end
        endcase
      end

      // A result is matched against the oldest request still waiting.
      if (out_valid && out_ready) begin
        if (awaited_updates.size() == 0) begin
          report_mismatch("result with no request waiting for it");
        end else begin
          want = awaited_updates.pop_front();
          compare_field("screen_write", 16'(screen_write), 16'(want.scr_wr));
          compare_field("screen_col", 16'(screen_col), 16'(want.scr_col));
          compare_field("screen_row", 16'(screen_row), 16'(want.scr_row));
          compare_field("screen_char", 16'(screen_char), 16'(want.scr_ch));
          compare_field("cursor_col", 16'(cursor_col), 16'(want.cur_col));
          compare_field("cursor_row", 16'(cursor_row), 16'(want.cur_row));
          compare_field("clear_box", 16'(clear_box), 16'(want.clr));
          compare_field("read_done", 16'(read_done), 16'(want.done));
          compare_field("read_length", 16'(read_length), 16'(want.rlen));
          compare_field("buffer_char", 16'(buffer_char), 16'(want.bch));
          if (want.done) reads_total++;
        end
        checked_total++;
      end

      if (in_valid && in_ready) begin
        edit_text_field(kind, key_char, requested_length, peek_index, fresh);
        awaited_updates.push_back(fresh);
      end
    end
    awaited_total = awaited_updates.size();
  end

endmodule

FILE: tb/sv/text_field_cursor_editor_top_tb.sv
`timescale 1ns / 1ps

// Drives requests and frame settings into the text field editor and gives the verdict;
// prediction and comparison sit in the checker beside the block.
module text_field_cursor_editor_top_tb;
  import tfce_pkg::*;

  localparam int StallLimit = 10000;
  localparam int LongHold   = 400;
  localparam int PhaseCount = 9;
  localparam int PhaseItems = 150;
  localparam int SettleGap  = 8;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  kind;
  logic [7:0]  key_char;
  logic [15:0] requested_length;
  logic [10:0] peek_index;
  logic        out_valid;
  logic        out_ready;
  logic        screen_write;
  logic [6:0]  screen_col;
  logic [4:0]  screen_row;
  logic [7:0]  screen_char;
  logic [6:0]  cursor_col;
  logic [4:0]  cursor_row;
  logic        clear_box;
  logic        read_done;
  logic [11:0] read_length;
  logic [7:0]  buffer_char;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_data;

  int mismatches;
  int outstanding;
  int results_checked;
  int reads_finished;

  int  issued = 0;
  int  frames_used = 0;
  int  holds_asked = 0;
  int  holds_served = 0;
  int  stalled_cycles = 0;
  bit  eager = 1'b0;

  text_field_cursor_editor_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .key_char(key_char), .requested_length(requested_length),
    .peek_index(peek_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .screen_write(screen_write), .screen_col(screen_col), .screen_row(screen_row),
    .screen_char(screen_char), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .clear_box(clear_box), .read_done(read_done), .read_length(read_length),
    .buffer_char(buffer_char),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  text_field_cursor_editor_checker editor_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .key_char(key_char), .requested_length(requested_length),
    .peek_index(peek_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .screen_write(screen_write), .screen_col(screen_col), .screen_row(screen_row),
    .screen_char(screen_char), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .clear_box(clear_box), .read_done(read_done), .read_length(read_length),
    .buffer_char(buffer_char),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .results_checked(results_checked), .reads_finished(reads_finished)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Gap before a request: none in eager stretches, otherwise mostly short and a few long.
  function automatic int pick_gap();
    int r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(0, 20);
    if (r < 6) return $urandom_range(2040, 2100);
    return $urandom_range(0, 65535);
  endfunction

  // Offers one request; fields the kind does not use carry random values.
  task automatic issue(input kind_t k, input int value);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    kind             <= k;
    key_char         <= (k == KIND_KEY) ? 8'(value) : 8'($urandom);
    requested_length <= (k == KIND_ARM) ? 16'(value) : 16'($urandom);
    peek_index       <= (k == KIND_PEEK) ? 11'(value) : 11'($urandom);
    do @(posedge clk); while (!in_ready);
    issued++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [6:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // New frame settings are written only once every result has come back.
  task automatic apply_frame(input logic [6:0] left, input logic [4:0] top,
                             input logic [6:0] width, input logic [4:0] height,
                             input logic mask);
    idle_sender();
    wait (outstanding == 0);
    repeat (SettleGap) @(posedge clk);
    write_register(CfgLeft, left);
    write_register(CfgTop, 7'(top));
    write_register(CfgWidth, width);
    write_register(CfgHeight, 7'(height));
    write_register(CfgMask, 7'(mask));
    frames_used++;
  endtask

  // One random request, or now and then a whole read: arm, some typing, return.
  task automatic random_request();
    int r, c;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      issue(KIND_ARM, pick_length());
      repeat ($urandom_range(0, 6)) issue(KIND_KEY, $urandom_range(32, 126));
      issue(KIND_KEY, KeyReturn);
    end else if (r < 70) begin
      c = $urandom_range(0, 99);
      if (c < 20) issue(KIND_KEY, KeyBackspace);
      else if (c < 35) issue(KIND_KEY, KeyReturn);
      else if (c < 40) issue(KIND_KEY, KeyTab);
      else if (c < 70) issue(KIND_KEY, $urandom_range(32, 126));
      else issue(KIND_KEY, $urandom_range(0, 255));
    end else if (r < 75) begin
      issue(KIND_CLEAR, 0);
    end else if (r < 81) begin
      issue(KIND_ARM, pick_length());
    end else if (r < 98) begin
      issue(KIND_PEEK, ($urandom_range(0, 9) < 7) ? $urandom_range(0, 200)
                                                  : $urandom_range(0, 2047));
    end else begin
      issue(KIND_FLUSH, 0);
    end
  endtask

  // Receiver: random stretches of ready and stall, plus long hold-offs on request.
  initial begin
    bit drive_level;
    int span;
    out_ready = 1'b0;
    forever begin
      if (holds_served < holds_asked) begin
        holds_served++;
        drive_level = 1'b0;
        span        = LongHold;
      end else if ($urandom_range(0, 99) < 60) begin
        drive_level = 1'b1;
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 150) : $urandom_range(1, 12);
      end else begin
        drive_level = 1'b0;
        span = ($urandom_range(0, 6) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      end
      @(negedge clk);
      out_ready <= drive_level;
      repeat (span - 1) @(negedge clk);
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  initial begin
    while (stalled_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("No request or result moved for %0d cycles.", StallLimit);
    $display("text_field_cursor_editor_top regression: fail");
    $finish;
  end

  // Main sequence: reset, directed requests, then phases of random requests.
  initial begin
    int mid_point, phase_end, l, t, w, h;
    bit paused;
    rst              = 1'b1;
    in_valid         = 1'b0;
    kind             = KIND_KEY;
    key_char         = 8'h00;
    requested_length = 16'h0000;
    peek_index       = 11'd0;
    cfg_we           = 1'b0;
    cfg_index        = CfgLeft;
    cfg_data         = 7'd0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset state under the default frame.
    issue(KIND_PEEK, 0);
    issue(KIND_KEY, 8'h00);
    issue(KIND_PEEK, 2047);

    // A three by two frame to reach wrapping, the last cell and reads.
    apply_frame(7'd5, 5'd3, 7'd3, 5'd2, 1'b0);
    issue(KIND_CLEAR, 0);
    issue(KIND_KEY, KeyBackspace);
    issue(KIND_KEY, 8'h41);
    issue(KIND_KEY, 8'hFF);
    issue(KIND_KEY, 8'h7E);
    issue(KIND_KEY, KeyTab);
    issue(KIND_KEY, KeyReturn);
    issue(KIND_KEY, 8'h80);
    issue(KIND_KEY, 8'h31);
    issue(KIND_KEY, 8'h32);
    issue(KIND_KEY, KeyBackspace);
    issue(KIND_KEY, KeyBackspace);
    issue(KIND_KEY, KeyBackspace);
    issue(KIND_ARM, 16'hFFFF);
    issue(KIND_KEY, KeyReturn);
    issue(KIND_ARM, 0);
    issue(KIND_ARM, 1);
    issue(KIND_KEY, KeyReturn);
    issue(KIND_KEY, KeyReturn);
    issue(KIND_PEEK, 2);
    issue(KIND_FLUSH, 0);
    issue(KIND_PEEK, 1);

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: apply_frame(7'd0, 5'd0, 7'd80, 5'd25, 1'b0);
        1: apply_frame(7'd5, 5'd3, 7'd3, 5'd2, 1'b1);
        2: apply_frame(7'd0, 5'd0, 7'd1, 5'd1, 1'b0);
        3: apply_frame(7'd79, 5'd24, 7'd1, 5'd1, 1'b1);
        4: apply_frame(7'd79, 5'd24, 7'd80, 5'd25, 1'b0);
        7: apply_frame(7'd10, 5'd5, 7'd20, 5'd4, 1'b1);
        default: begin
          l = $urandom_range(0, 79);
          w = $urandom_range(1, 80 - l);
          t = $urandom_range(0, 24);
          h = $urandom_range(1, 25 - t);
          apply_frame(7'(l), 5'(t), 7'(w), 5'(h), 1'($urandom));
        end
      endcase

      // One phase keeps offering requests while the receiver holds off.
      eager = (phase == 1) || ($urandom_range(0, 3) == 0);
      if (phase == 1) holds_asked++;
      if ($urandom_range(0, 1) == 1) issue(KIND_CLEAR, 0);

      phase_end = issued + PhaseItems;
      mid_point = issued + PhaseItems / 2;
      paused    = 1'b0;
      while (issued < phase_end) begin
        random_request();
        if (!paused && issued >= mid_point) begin
          // Let the block run dry before carrying on.
          paused = 1'b1;
          idle_sender();
          wait (outstanding == 0);
        end
      end
    end

    idle_sender();
    wait (outstanding == 0);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests over %0d frame settings, tiny, masked and off-screen ones too.",
             issued, frames_used);
    $display("Compared %0d results, %0d of them finished reads; %0d mismatches.",
             results_checked, reads_finished, mismatches);
    if (mismatches == 0) begin
      $display("text_field_cursor_editor_top regression: pass");
    end else begin
      $display("text_field_cursor_editor_top regression: fail");
    end
    $finish;
  end

endmodule
